// ----- sv/apfm_pkg.sv -----
// package for the as path filter match block
// holds payload structs, token and phase types, register and mode codes
// no dependencies
package apfm_pkg;

  // configuration port
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_TARGET = 1'b1;

  // match modes
  localparam logic [2:0] MODE_EMPTY   = 3'd0;
  localparam logic [2:0] MODE_PEER    = 3'd1;
  localparam logic [2:0] MODE_SOURCE  = 3'd2;
  localparam logic [2:0] MODE_TRANSIT = 3'd3;
  localparam logic [2:0] MODE_ANY     = 3'd4;
  localparam logic [2:0] MODE_RESET   = MODE_ANY;

  // token queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // input beat
  typedef struct packed {
    logic [7:0] path_byte;
    logic       byte_present;
    logic       path_end;
  } item_t;

  // result beat
  typedef struct packed {
    logic matched;
    logic malformed;
  } result_t;

  // parser phase
  typedef enum logic [1:0] {
    PH_TYPE,
    PH_COUNT,
    PH_AS
  } phase_t;

  // byte class worked out by the front
  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_TYPE,
    CLS_CNT_ZERO,
    CLS_CNT_SOME,
    CLS_AS_BYTE,
    CLS_AS_LAST
  } tok_cls_t;

  typedef struct packed {
    tok_cls_t   cls;
    logic [7:0] data;
    logic       last;
    logic       bad;
  } token_t;

endpackage

// ----- sv/apfm_front.sv -----
// front end: accepts input beats and classifies each byte of the path
// tracks segment header and as byte position; depends on apfm_pkg
module apfm_front
  import apfm_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  output logic   item_stall,
  input  item_t  item,
  input  logic   q_full,
  output logic   push,
  output token_t push_tok
);

  phase_t     phase, phase_next, phase_step;
  logic [7:0] ases_left, ases_left_next;
  logic [1:0] byte_of_as, byte_of_as_next;
  logic       take, has_byte, byte_zero, as_done;

  assign item_stall = q_full;
  assign take       = item_valid && !q_full;
  assign has_byte   = take && item.byte_present;
  assign byte_zero  = (item.path_byte == 8'd0);
  assign as_done    = (byte_of_as == 2'd3);

  // phase after this byte
  always_comb begin
    phase_step = phase;
    if (has_byte) begin
      unique case (phase)
        PH_TYPE:  phase_step = PH_COUNT;
        PH_COUNT: phase_step = byte_zero ? PH_TYPE : PH_AS;
        PH_AS:    phase_step = (as_done && ases_left == 8'd1) ? PH_TYPE : PH_AS;
        default:  phase_step = PH_TYPE;
      endcase
    end
  end

  // next state: back to segment start at the end of a path
  always_comb begin
    phase_next = phase_step;
    if (take && item.path_end) begin
      phase_next = PH_TYPE;
    end
  end

  // outputs: token class and counters
  always_comb begin
    push_tok.cls    = CLS_NONE;
    push_tok.data   = item.path_byte;
    push_tok.last   = item.path_end;
    push_tok.bad    = (phase_step != PH_TYPE);
    ases_left_next  = ases_left;
    byte_of_as_next = byte_of_as;
    if (has_byte) begin
      unique case (phase)
        PH_TYPE: begin
          push_tok.cls = CLS_TYPE;
        end
        PH_COUNT: begin
          push_tok.cls    = byte_zero ? CLS_CNT_ZERO : CLS_CNT_SOME;
          ases_left_next  = item.path_byte;
          byte_of_as_next = 2'd0;
        end
        PH_AS: begin
          byte_of_as_next = byte_of_as + 2'd1;
          if (as_done) begin
            push_tok.cls   = CLS_AS_LAST;
            ases_left_next = ases_left - 8'd1;
          end else begin
            push_tok.cls = CLS_AS_BYTE;
          end
        end
        default: push_tok.cls = CLS_NONE;
      endcase
    end
    if (take && item.path_end) begin
      ases_left_next  = 8'd0;
      byte_of_as_next = 2'd0;
    end
  end

  // only beats with a byte or a path end go on
  assign push = take && (item.byte_present || item.path_end);

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TYPE;
      ases_left  <= 8'd0;
      byte_of_as <= 2'd0;
    end else begin
      phase      <= phase_next;
      ases_left  <= ases_left_next;
      byte_of_as <= byte_of_as_next;
    end
  end

endmodule

// ----- sv/apfm_queue.sv -----
// short token queue between front and back ends
// register file with read and write pointers; depends on apfm_pkg
module apfm_queue
  import apfm_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  token_t push_tok,
  output logic   full,
  input  logic   pop,
  output logic   pop_valid,
  output token_t pop_tok
);

  token_t             store [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push, do_pop;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_tok   = store[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_tok;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue fill count above depth");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - Q_CNT_W'(1)))
    else $error("queue count did not drop on pop");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (rd_ptr == wr_ptr))
    else $error("empty queue with pointers apart");
`endif

endmodule

// ----- sv/apfm_back.sv -----
// back end: assembles as numbers, tracks hits and issues the result beat
// output register decouples the result stall; depends on apfm_pkg
module apfm_back
  import apfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [2:0]  match_mode,
  input  logic [31:0] target_as,
  input  logic        tok_valid,
  input  token_t      tok,
  output logic        tok_pop,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result
);

  logic [23:0] as_shift;
  logic        in_first, peer_hit, earlier_hit, pending_hit, open_has_as, saw_any;
  logic        in_first_next, peer_hit_next, earlier_hit_next, pending_hit_next;
  logic        open_has_as_next, saw_any_next, hit, m;

  assign tok_pop = tok_valid && !(result_valid && result_stall);
  assign hit     = ({as_shift, tok.data} == target_as);

  // hit tracking for this token
  always_comb begin
    in_first_next    = in_first;
    peer_hit_next    = peer_hit;
    earlier_hit_next = earlier_hit;
    pending_hit_next = pending_hit;
    open_has_as_next = open_has_as;
    saw_any_next     = saw_any || (tok.cls != CLS_NONE);
    case (tok.cls) inside
      CLS_CNT_ZERO, CLS_CNT_SOME: begin
        earlier_hit_next = earlier_hit || pending_hit;
        pending_hit_next = 1'b0;
        open_has_as_next = (tok.cls == CLS_CNT_SOME);
        if (tok.cls == CLS_CNT_ZERO) begin
          in_first_next = 1'b0;
        end
      end
      CLS_AS_LAST: begin
        if (in_first) begin
          peer_hit_next = hit;
          in_first_next = 1'b0;
        end
        earlier_hit_next = earlier_hit || pending_hit;
        pending_hit_next = hit;
      end
      default: ;
    endcase
  end

  // match decision at path end
  always_comb begin
    unique case (match_mode)
      MODE_EMPTY:   m = !saw_any_next;
      MODE_PEER:    m = peer_hit_next;
      MODE_SOURCE:  m = open_has_as_next && pending_hit_next;
      MODE_TRANSIT: m = earlier_hit_next;
      MODE_ANY:     m = earlier_hit_next || pending_hit_next;
      default:      m = 1'b0;
    endcase
  end

  // as byte shift line
  always_ff @(posedge clk) begin
    if (tok_pop && tok.cls == CLS_AS_BYTE) begin
      as_shift <= {as_shift[15:0], tok.data};
    end
  end

  // path state, cleared after each result
  always_ff @(posedge clk) begin
    if (rst) begin
      in_first    <= 1'b1;
      peer_hit    <= 1'b0;
      earlier_hit <= 1'b0;
      pending_hit <= 1'b0;
      open_has_as <= 1'b0;
      saw_any     <= 1'b0;
    end else if (tok_pop) begin
      if (tok.last) begin
        in_first    <= 1'b1;
        peer_hit    <= 1'b0;
        earlier_hit <= 1'b0;
        pending_hit <= 1'b0;
        open_has_as <= 1'b0;
        saw_any     <= 1'b0;
      end else begin
        in_first    <= in_first_next;
        peer_hit    <= peer_hit_next;
        earlier_hit <= earlier_hit_next;
        pending_hit <= pending_hit_next;
        open_has_as <= open_has_as_next;
        saw_any     <= saw_any_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (tok_pop && tok.last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && tok.last) begin
      result.matched   <= m && !tok.bad;
      result.malformed <= tok.bad;
    end
  end

endmodule

// ----- sv/as_path_filter_match_top.sv -----
// Matches a BGP AS path, fed one byte per beat, against a configured AS
// number under a configured mode and gives one result beat per path. The
// block takes one input beat per cycle while the token queue has room. A
// path end passes through the token queue before its result is registered.
// A four-entry token queue between parser and match logic, plus the result
// register, lets input keep flowing for a few beats while the result side
// is stalled. Registers: match_mode at 0x0, target_as at 0x4.
module as_path_filter_match_top
  import apfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input channel
  input  logic              item_valid,
  output logic              item_stall,
  input  item_t             item,
  // result channel
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [2:0]  match_mode;
  logic [31:0] target_as;
  logic        cfg_write, q_full, push, tok_valid, tok_pop;
  token_t      push_tok, tok;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_mode <= MODE_RESET;
      target_as  <= 32'd0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_MODE:   match_mode <= pwdata[2:0];
        REG_TARGET: target_as  <= pwdata;
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[2])
      REG_MODE:   prdata = {29'd0, match_mode};
      REG_TARGET: prdata = target_as;
      default:    prdata = '0;
    endcase
  end

  apfm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .push       (push),
    .push_tok   (push_tok)
  );

  apfm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_tok  (push_tok),
    .full      (q_full),
    .pop       (tok_pop),
    .pop_valid (tok_valid),
    .pop_tok   (tok)
  );

  apfm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .match_mode   (match_mode),
    .target_as    (target_as),
    .tok_valid    (tok_valid),
    .tok          (tok),
    .tok_pop      (tok_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTHESIS
  a_bad_no_match: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.malformed && result.matched))
    else $error("malformed path reported as matched");

  a_cfg_mode: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && paddr[2] == REG_MODE) |=> (match_mode == $past(pwdata[2:0])))
    else $error("mode register not written");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> q_full)
    else $error("input stalled with queue room");
`endif

endmodule

// ----- tb/sv/tb_as_path_filter_match_top.sv -----
// testbench for as_path_filter_match_top: directed paths, register settings and random paths
// drives beats with random gaps and result stalls, predicts each verdict in step with the input
// depends on apfm_pkg and as_path_filter_match_top
module tb_as_path_filter_match_top;
  timeunit 1ns;
  timeprecision 1ps;

  import apfm_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // spare mode codes, no match defined for them
  localparam logic [2:0] MODE_SPARE_MIN = MODE_ANY + 3'd1;
  localparam logic [2:0] MODE_SPARE_MAX = 3'd7;

  localparam int unsigned SETTLE_CYCLES = Q_DEPTH + 8;
  localparam int unsigned HOLD_CYCLES = 100;
  localparam int unsigned RANDOM_BEATS = 1250;

  logic              clk = 1'b0;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  item_t             item;
  logic              result_valid;
  logic              result_stall;
  result_t           result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // register copies
  logic [2:0]  cfg_mode;
  logic [31:0] cfg_target;

  // path parser copy
  phase_t      pr_phase;
  logic [7:0]  pr_ases_left;
  logic [1:0]  pr_as_byte;
  logic [31:0] pr_as_shift;
  bit          pr_first_seg;
  bit          pr_peer_hit;
  bit          pr_earlier_hit;
  bit          pr_pending_hit;
  bit          pr_open_has_as;
  bit          pr_saw_byte;

  result_t     expected_verdicts[$];

  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned paths_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned verdicts_seen = 0;
  int unsigned burst_left = 0;
  bit          sender_eager = 1'b0;
  int unsigned hold_asked = 0;
  int unsigned hold_done = 0;

  as_path_filter_match_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // predictor: parser state back to the start of a path
  task automatic clear_path_state();
    pr_phase       = PH_TYPE;
    pr_ases_left   = '0;
    pr_as_byte     = '0;
    pr_as_shift    = '0;
    pr_first_seg   = 1'b1;
    pr_peer_hit    = 1'b0;
    pr_earlier_hit = 1'b0;
    pr_pending_hit = 1'b0;
    pr_open_has_as = 1'b0;
    pr_saw_byte    = 1'b0;
  endtask

  // predictor: advance on one accepted beat, queue a verdict at the path end
  task automatic path_match_predict(input item_t b);
    bit      hit;
    bit      bad;
    bit      m;
    result_t v;
    if (b.byte_present) begin
      pr_saw_byte = 1'b1;
      case (pr_phase)
        PH_TYPE: pr_phase = PH_COUNT;
        PH_COUNT: begin
          // a new segment: the last AS so far is no longer the final one
          pr_earlier_hit = pr_earlier_hit | pr_pending_hit;
          pr_pending_hit = 1'b0;
          pr_open_has_as = (b.path_byte != 8'd0);
          if (b.path_byte == 8'd0) begin
            pr_first_seg = 1'b0;
            pr_phase = PH_TYPE;
          end else begin
            pr_ases_left = b.path_byte;
            pr_as_byte = '0;
            pr_as_shift = '0;
            pr_phase = PH_AS;
          end
        end
        default: begin
          pr_as_shift = {pr_as_shift[23:0], b.path_byte};
          pr_as_byte = pr_as_byte + 2'd1;
          if (pr_as_byte == 2'd0) begin
            hit = (pr_as_shift == cfg_target);
            if (pr_first_seg) begin
              pr_peer_hit = hit;
              pr_first_seg = 1'b0;
            end
            pr_earlier_hit = pr_earlier_hit | pr_pending_hit;
            pr_pending_hit = hit;
            pr_as_shift = '0;
            pr_ases_left = pr_ases_left - 8'd1;
            if (pr_ases_left == 8'd0) pr_phase = PH_TYPE;
          end
        end
      endcase
    end
    if (b.path_end) begin
      bad = (pr_phase != PH_TYPE);
      case (cfg_mode)
        MODE_EMPTY:   m = !pr_saw_byte;
        MODE_PEER:    m = pr_peer_hit;
        MODE_SOURCE:  m = pr_open_has_as && pr_pending_hit;
        MODE_TRANSIT: m = pr_earlier_hit;
        MODE_ANY:     m = pr_earlier_hit || pr_pending_hit;
        default:      m = 1'b0;
      endcase
      v.matched = m && !bad;
      v.malformed = bad;
      expected_verdicts.push_back(v);
      paths_sent++;
      clear_path_state();
    end
  endtask

  // sender gap: mostly none or short, a few long, bursts with none
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (sender_eager) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      burst_left = $urandom_range(10, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // send one beat and predict once it is taken
  task automatic send_beat(input item_t b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= b;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    beats_sent++;
    path_match_predict(b);
  endtask

  // send path bytes, the end flag on the last byte or on a beat of its own
  task automatic send_path(input byte_q_t bytes, input bit end_alone, input bit stray);
    item_t b;
    for (int i = 0; i < bytes.size(); i++) begin
      if (stray && $urandom_range(0, 19) == 0)
        send_beat(item_t'{path_byte: 8'($urandom()), byte_present: 1'b0, path_end: 1'b0});
      b.path_byte = bytes[i];
      b.byte_present = 1'b1;
      b.path_end = !end_alone && (i == bytes.size() - 1);
      send_beat(b);
    end
    if (end_alone || bytes.size() == 0)
      send_beat(item_t'{path_byte: 8'($urandom()), byte_present: 1'b0, path_end: 1'b1});
  endtask

  // wait for every verdict, then let the token queue run dry
  task automatic drain();
    item_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write with read-back, only while idle
  task automatic cfg_write(input logic reg_idx, input logic [31:0] value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'({reg_idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_MODE) cfg_mode = value[2:0];
    else cfg_target = value;
    reg_writes++;
    // back-to-back read of the same register
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata != value) begin
      $error("prdata: expected %h, got %h", value, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // AS number drawn around the target so that hits are common
  function automatic logic [31:0] pick_as();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: return cfg_target;
      4:          return cfg_target ^ (32'h1 << $urandom_range(0, 31));
      5:          return '0;
      6:          return '1;
      default:    return $urandom();
    endcase
  endfunction

  // complete path of a few short segments, some of them empty
  function automatic byte_q_t well_formed_path();
    byte_q_t     q;
    int unsigned nseg;
    int unsigned cnt;
    logic [31:0] asn;
    nseg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    for (int s = 0; s < nseg; s++) begin
      q.push_back(8'($urandom()));
      cnt = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 4);
      q.push_back(8'(cnt));
      for (int a = 0; a < cnt; a++) begin
        asn = pick_as();
        q.push_back(asn[31:24]);
        q.push_back(asn[23:16]);
        q.push_back(asn[15:8]);
        q.push_back(asn[7:0]);
      end
    end
    return q;
  endfunction

  // path cut short, or a segment with a large count that never completes
  function automatic byte_q_t broken_path();
    byte_q_t     q;
    int unsigned keep;
    if ($urandom_range(0, 1) == 0) begin
      q = well_formed_path();
      while (q.size() < 2) q = well_formed_path();
      keep = $urandom_range(1, q.size() - 1);
      while (q.size() > keep) void'(q.pop_back());
    end else begin
      q.push_back(8'($urandom()));
      q.push_back(8'($urandom_range(5, 255)));
      repeat ($urandom_range(0, 15)) q.push_back(8'($urandom()));
    end
    return q;
  endfunction

  // reset values: any AS, target zero, with a byteless beat at the start of the path
  task automatic test_reset_defaults();
    byte_q_t q;
    q = {8'hFF, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
    send_beat(item_t'{path_byte: 8'hA5, byte_present: 1'b0, path_end: 1'b0});
    send_path(q, 1'b0, 1'b0);
  endtask

  // empty first segment gives no peer match
  task automatic test_empty_first_segment();
    byte_q_t q;
    cfg_write(REG_MODE, 32'(MODE_PEER));
    cfg_write(REG_TARGET, 32'hFFFF_FFFF);
    q = {8'h02, 8'h00, 8'h02, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_path(q, 1'b0, 1'b0);
  endtask

  // empty final segment gives no source match
  task automatic test_empty_final_segment();
    byte_q_t q;
    cfg_write(REG_MODE, 32'(MODE_SOURCE));
    q = {8'h02, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00};
    send_path(q, 1'b0, 1'b0);
  endtask

  // empty path matches only in empty mode
  task automatic test_empty_path();
    byte_q_t q;
    cfg_write(REG_MODE, 32'(MODE_EMPTY));
    send_path(q, 1'b1, 1'b0);
  endtask

  // path ending inside a segment is malformed
  task automatic test_truncated_path();
    byte_q_t q;
    cfg_write(REG_MODE, 32'(MODE_ANY));
    q = {8'h00, 8'hFF};
    send_path(q, 1'b0, 1'b0);
  endtask

  // undefined mode never matches
  task automatic test_undefined_mode();
    byte_q_t q;
    cfg_write(REG_MODE, 32'(MODE_SPARE_MAX));
    send_path(q, 1'b1, 1'b0);
  endtask

  // receiver holds off while the sender keeps offering short paths
  task automatic test_result_backpressure();
    cfg_write(REG_MODE, 32'(MODE_EMPTY));
    sender_eager = 1'b1;
    hold_asked <= hold_asked + 1;
    repeat (30)
      send_beat(item_t'{path_byte: 8'($urandom()), byte_present: 1'b0, path_end: 1'b1});
    sender_eager = 1'b0;
    drain();
  endtask

  // random settings, each followed by a run of mostly well-formed paths
  task automatic test_random_paths();
    int unsigned first;
    int unsigned r;
    item_t       b;
    first = beats_sent;
    while (beats_sent - first < RANDOM_BEATS) begin
      if ($urandom_range(0, 9) < 8)
        cfg_write(REG_MODE, 32'($urandom_range(MODE_EMPTY, MODE_ANY)));
      else
        cfg_write(REG_MODE, 32'($urandom_range(MODE_SPARE_MIN, MODE_SPARE_MAX)));
      r = $urandom_range(0, 5);
      cfg_write(REG_TARGET, (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom());
      repeat ($urandom_range(3, 10)) begin
        r = $urandom_range(0, 99);
        if (r < 72) begin
          send_path(well_formed_path(), $urandom_range(0, 4) == 0, 1'b1);
        end else if (r < 87) begin
          send_path(broken_path(), $urandom_range(0, 4) == 0, 1'b1);
        end else begin
          // raw noise ending in one path end
          repeat ($urandom_range(0, 9)) begin
            b = item_t'($urandom());
            b.path_end = 1'b0;
            send_beat(b);
          end
          b = item_t'($urandom());
          b.path_end = 1'b1;
          send_beat(b);
        end
      end
    end
    drain();
  endtask

  // result side: stretches of no stall and of random stall, plus requested holds
  initial begin : result_side
    int unsigned stretch;
    int unsigned pct;
    stretch = 0;
    pct = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_done) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = hold_asked;
        result_stall <= 1'b0;
      end else begin
        if (stretch == 0) begin
          stretch = $urandom_range(10, 200);
          pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
        end
        stretch--;
        if (pct != 0 && $urandom_range(0, 99) < 3) begin
          result_stall <= 1'b1;
          repeat ($urandom_range(5, 30)) @(posedge clk);
          result_stall <= 1'b0;
        end else begin
          result_stall <= ($urandom_range(0, 99) < pct);
        end
      end
    end
  end

  // compare each result beat with the oldest verdict
  initial begin : result_check
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        verdicts_seen++;
        if (expected_verdicts.size() == 0) begin
          $error("result beat with no verdict expected: matched %0b malformed %0b",
                 result.matched, result.malformed);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          if (result.matched !== want.matched) begin
            $error("matched: expected %0b, got %0b", want.matched, result.matched);
            mismatches++;
          end
          if (result.malformed !== want.malformed) begin
            $error("malformed: expected %0b, got %0b", want.malformed, result.malformed);
            mismatches++;
          end
        end
      end
    end
  end

  // hang guard
  initial begin : run_limit
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // test sequence
  initial begin : run_tests
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cfg_mode = MODE_RESET;
    cfg_target = '0;
    clear_path_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_empty_first_segment();
    test_empty_final_segment();
    test_empty_path();
    test_truncated_path();
    test_undefined_mode();
    test_result_backpressure();
    test_random_paths();

    $display("run covered %0d input beats in %0d paths over %0d register writes",
             beats_sent, paths_sent, reg_writes);
    $display("%0d verdicts checked, all modes, malformed paths and one long result hold-off",
             verdicts_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
